// ----- rtl/pat_pkg.sv -----
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, codes and types of the positional array table.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int INDEX_W = 6;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        OP_ERR    = 3'd0,
        OP_INS    = 3'd1,
        OP_DEL    = 3'd2,
        OP_SEARCH = 3'd3,
        OP_TRAV   = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   pos;
        logic [VAL_W-1:0]   val;
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

endpackage

// ----- rtl/pat_if.sv -----
// ----------------------------------------------------------------------------
// pat_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pat_req_if;
    logic                              valid;
    logic                              ready;
    logic [pat_pkg::CMD_W-1:0]         command;
    logic [pat_pkg::POS_W-1:0]         position;
    logic signed [pat_pkg::VAL_W-1:0]  value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface pat_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pat_pkg::STAT_W-1:0]          status;
    logic [pat_pkg::INDEX_W-1:0]         index;
    logic signed [pat_pkg::VAL_W-1:0]    element;
    logic                                last;

    modport source (output valid, status, index, element, last, input ready);
    modport sink   (input valid, status, index, element, last, output ready);
endinterface

// ----- rtl/pat_front.sv -----
// ----------------------------------------------------------------------------
// pat_front
// Accepts command items, checks them against a shadow count and queues ops.
// ----------------------------------------------------------------------------
module pat_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    pat_req_if.sink                    req,
    output logic                       op_valid,
    input  logic                       op_ready,
    output pat_pkg::op_t               op,
    output logic [pat_pkg::CNT_W-1:0]  shadow_cnt
);

    logic [pat_pkg::CNT_W-1:0] cnt_reg;
    logic [pat_pkg::CNT_W-1:0] cnt_next;
    logic                      push;
    logic [pat_pkg::POS_W-1:0] pos_cnt;

    assign req.ready  = op_ready;
    assign op_valid   = req.valid;
    assign push       = req.valid && op_ready;
    assign shadow_cnt = cnt_reg;
    assign pos_cnt    = pat_pkg::POS_W'(cnt_reg);

    always_comb
    begin
        op.kind   = pat_pkg::OP_ERR;
        op.status = pat_pkg::ST_OK;
        op.pos    = req.position;
        op.val    = req.value;
        cnt_next  = cnt_reg;
        case (req.command)
            pat_pkg::CMD_INSERT:
            begin
                if (req.position > pos_cnt)
                begin
                    op.status = pat_pkg::ST_BADPOS;
                end
                else if (cnt_reg == pat_pkg::CNT_W'(pat_pkg::DEPTH))
                begin
                    op.status = pat_pkg::ST_FULL;
                end
                else
                begin
                    op.kind  = pat_pkg::OP_INS;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pat_pkg::CMD_DELETE:
            begin
                if (req.position >= pos_cnt)
                begin
                    op.status = pat_pkg::ST_BADPOS;
                end
                else
                begin
                    op.kind  = pat_pkg::OP_DEL;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            pat_pkg::CMD_SEARCH:
            begin
                if (cnt_reg == '0)
                begin
                    op.status = pat_pkg::ST_NOTFOUND;
                end
                else
                begin
                    op.kind = pat_pkg::OP_SEARCH;
                end
            end
            default:
            begin
                if (cnt_reg == '0)
                begin
                    op.status = pat_pkg::ST_EMPTY;
                end
                else
                begin
                    op.kind = pat_pkg::OP_TRAV;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (push)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/pat_queue.sv -----
// ----------------------------------------------------------------------------
// pat_queue
// Short op queue between the front and the back.
// ----------------------------------------------------------------------------
module pat_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  pat_pkg::op_t  wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output pat_pkg::op_t  rd_op
);

    pat_pkg::op_t               slot_reg [pat_pkg::QDEPTH];
    logic [pat_pkg::QPTR_W-1:0] wptr_reg;
    logic [pat_pkg::QPTR_W-1:0] rptr_reg;
    logic [pat_pkg::QCNT_W-1:0] fill_reg;
    logic                       push;
    logic                       pop;

    assign wr_ready = (fill_reg != pat_pkg::QCNT_W'(pat_pkg::QDEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_op    = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/pat_back.sv -----
// ----------------------------------------------------------------------------
// pat_back
// Cell array with shift and rotate, scan sequencer and result register.
// ----------------------------------------------------------------------------
module pat_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  pat_pkg::op_t  op,
    pat_rsp_if.source     rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [pat_pkg::VAL_W-1:0]  cells_reg  [pat_pkg::DEPTH];
    logic [pat_pkg::VAL_W-1:0]  cells_next [pat_pkg::DEPTH];
    logic [pat_pkg::CNT_W-1:0]  cnt_reg;
    logic [pat_pkg::CNT_W-1:0]  cnt_next;
    logic [pat_pkg::IDX_W-1:0]  idx_reg;
    logic [pat_pkg::IDX_W-1:0]  idx_next;
    logic                       found_reg;
    logic                       found_next;
    logic [pat_pkg::IDX_W-1:0]  fidx_reg;
    logic [pat_pkg::IDX_W-1:0]  fidx_next;
    logic [pat_pkg::VAL_W-1:0]  key_reg;
    logic [pat_pkg::VAL_W-1:0]  key_next;
    logic                       trav_reg;
    logic                       trav_next;
    logic [pat_pkg::POS_W-1:0]  cell_pos;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [pat_pkg::STAT_W-1:0] out_status_reg;
    logic [pat_pkg::STAT_W-1:0] out_status_next;
    logic [pat_pkg::INDEX_W-1:0] out_index_reg;
    logic [pat_pkg::INDEX_W-1:0] out_index_next;
    logic [pat_pkg::VAL_W-1:0]  out_element_reg;
    logic [pat_pkg::VAL_W-1:0]  out_element_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    pat_pkg::cell_op_t          cell_op;
    logic [pat_pkg::CNT_W-1:0]  cnt_m1;
    logic                       out_free;
    logic                       at_last;
    logic                       hit;
    logic [pat_pkg::IDX_W-1:0]  hit_idx;

    assign out_free    = !out_valid_reg || rsp.ready;
    assign cnt_m1      = cnt_reg - 1'b1;
    assign at_last     = (pat_pkg::CNT_W'(idx_reg) == cnt_m1);
    assign hit         = found_reg || (cells_reg[0] == key_reg);
    assign hit_idx     = found_reg ? fidx_reg : idx_reg;
    assign op_ready    = (state_reg == S_IDLE) && out_free;

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.index   = out_index_reg;
    assign rsp.element = out_element_reg;
    assign rsp.last    = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        fidx_next        = fidx_reg;
        key_next         = key_reg;
        trav_next        = trav_reg;
        cell_pos         = op.pos;
        cell_op          = pat_pkg::CELL_HOLD;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_element_next = out_element_reg;
        out_last_next    = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    out_status_next  = op.status;
                    out_index_next   = '0;
                    out_element_next = '0;
                    out_last_next    = 1'b1;
                    case (op.kind)
                        pat_pkg::OP_INS:
                        begin
                            cell_op        = pat_pkg::CELL_INS;
                            cnt_next       = cnt_reg + 1'b1;
                            out_valid_next = 1'b1;
                        end
                        pat_pkg::OP_DEL:
                        begin
                            cell_op        = pat_pkg::CELL_DEL;
                            cnt_next       = cnt_m1;
                            out_valid_next = 1'b1;
                        end
                        pat_pkg::OP_SEARCH,
                        pat_pkg::OP_TRAV:
                        begin
                            state_next = S_SCAN;
                            idx_next   = '0;
                            found_next = 1'b0;
                            key_next   = op.val;
                            trav_next  = (op.kind == pat_pkg::OP_TRAV);
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (out_free)
                begin
                    cell_op  = pat_pkg::CELL_ROT;
                    idx_next = idx_reg + 1'b1;
                    if (!found_reg && (cells_reg[0] == key_reg))
                    begin
                        found_next = 1'b1;
                        fidx_next  = idx_reg;
                    end
                    if (trav_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_status_next  = pat_pkg::ST_OK;
                        out_index_next   = pat_pkg::INDEX_W'(idx_reg);
                        out_element_next = cells_reg[0];
                        out_last_next    = at_last;
                    end
                    else if (at_last)
                    begin
                        out_valid_next   = 1'b1;
                        out_status_next  = hit ? pat_pkg::ST_OK : pat_pkg::ST_NOTFOUND;
                        out_index_next   = hit ? pat_pkg::INDEX_W'(hit_idx) : '0;
                        out_element_next = '0;
                        out_last_next    = 1'b1;
                    end
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < pat_pkg::DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            case (cell_op)
                pat_pkg::CELL_INS:
                begin
                    if (pat_pkg::POS_W'(i) == cell_pos)
                    begin
                        cells_next[i] = op.val;
                    end
                    else if ((i > 0) && (pat_pkg::POS_W'(i) > cell_pos))
                    begin
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                pat_pkg::CELL_DEL:
                begin
                    if ((i < pat_pkg::DEPTH - 1) && (pat_pkg::POS_W'(i) >= cell_pos))
                    begin
                        cells_next[i] = cells_reg[(i < pat_pkg::DEPTH - 1) ? i + 1 : i];
                    end
                end
                pat_pkg::CELL_ROT:
                begin
                    if (pat_pkg::CNT_W'(i) == cnt_m1)
                    begin
                        cells_next[i] = cells_reg[0];
                    end
                    else if ((i < pat_pkg::DEPTH - 1) && (pat_pkg::CNT_W'(i) < cnt_m1))
                    begin
                        cells_next[i] = cells_reg[(i < pat_pkg::DEPTH - 1) ? i + 1 : i];
                    end
                end
                default:
                begin
                    cells_next[i] = cells_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg        <= cells_next;
        idx_reg          <= idx_next;
        fidx_reg         <= fidx_next;
        key_reg          <= key_next;
        trav_reg         <= trav_next;
        out_status_reg   <= out_status_next;
        out_index_reg    <= out_index_next;
        out_element_reg  <= out_element_next;
        out_last_reg     <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/positional_array_table.sv -----
// ----------------------------------------------------------------------------
// positional_array_table
// Ordered table of signed words with insert, delete, search and traverse.
// ----------------------------------------------------------------------------
// The front checks each command item against its own copy of the live count
// and hands an op through a two-entry queue to the back, which holds the
// entries in a row of cells. Insert, delete and every rejected command are
// done by the back in its idle state with one result each, so such items
// flow at one per cycle while the result side is free; the result register
// is loaded as the back takes the op from the queue. Search and traverse
// move the back into its scan state and then rotate the live cells past
// cell zero, one entry per cycle while the result side is free, until the
// last live entry has passed; traverse gives one result per rotation cycle
// and search gives its single result on the last of them. A stalled result
// holds the back; the front keeps accepting until the queue is full.
module positional_array_table
(
    input  logic       clk,
    input  logic       rst_n,
    pat_req_if.sink    req,
    pat_rsp_if.source  rsp
);

    logic                      fq_valid;
    logic                      fq_ready;
    pat_pkg::op_t              fq_op;
    logic                      qb_valid;
    logic                      qb_ready;
    pat_pkg::op_t              qb_op;
    logic [pat_pkg::CNT_W-1:0] shadow_cnt;

    pat_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .op_valid   (fq_valid),
        .op_ready   (fq_ready),
        .op         (fq_op),
        .shadow_cnt (shadow_cnt)
    );

    pat_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_op    (fq_op),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_op    (qb_op)
    );

    pat_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (qb_valid),
        .op_ready (qb_ready),
        .op       (qb_op),
        .rsp      (rsp)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        shadow_cnt <= pat_pkg::CNT_W'(pat_pkg::DEPTH))
        else $error("shadow count above depth");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        (qb_valid && qb_ready && (qb_op.kind == pat_pkg::OP_ERR))
        |=> (rsp.valid && (rsp.status != pat_pkg::ST_OK) && rsp.last))
        else $error("rejected op did not give a single error result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != pat_pkg::ST_OK))
        |-> (rsp.last && (rsp.index == '0) && (rsp.element == '0)))
        else $error("error result with nonzero payload");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.command == pat_pkg::CMD_INSERT)
            && (shadow_cnt == pat_pkg::CNT_W'(pat_pkg::DEPTH)))
        |=> (shadow_cnt == pat_pkg::CNT_W'(pat_pkg::DEPTH)))
        else $error("insert into full table changed the count");

endmodule

// ----- sim/positional_array_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_table_checker
// Watches the command and result channels of the table. It keeps a shadow
// copy of the entries and the live count, works out the results of every
// accepted command, and compares each accepted result field by field with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module positional_array_table_checker
    import pat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pat_req_if   req,
    pat_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] index;
        logic [VAL_W-1:0]   element;
        logic               last;
    } answer_t;

    answer_t          answer_q[$];
    logic [VAL_W-1:0] rows [DEPTH];
    int unsigned      row_count;
    int               fails;
    int               seen;

    function automatic void push_answer(input logic [STAT_W-1:0] st, input int unsigned idx,
                                        input logic [VAL_W-1:0] elem, input logic fin);
        answer_t a;
        a.status  = st;
        a.index   = idx[INDEX_W-1:0];
        a.element = elem;
        a.last    = fin;
        answer_q.push_back(a);
    endfunction

    function automatic void predict_answers(input logic [CMD_W-1:0] cmd,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VAL_W-1:0] val);
        int unsigned i;
        int unsigned at;
        bit          hit;
        at  = pos;
        hit = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                if (at > row_count)
                    push_answer(ST_BADPOS, 0, '0, 1'b1);
                else if (row_count >= DEPTH)
                    push_answer(ST_FULL, 0, '0, 1'b1);
                else
                begin
                    for (i = row_count; i > at; i--)
                        rows[i] = rows[i - 1];
                    rows[at] = val;
                    row_count++;
                    push_answer(ST_OK, 0, '0, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                if (at >= row_count)
                    push_answer(ST_BADPOS, 0, '0, 1'b1);
                else
                begin
                    for (i = at; i + 1 < row_count; i++)
                        rows[i] = rows[i + 1];
                    row_count--;
                    push_answer(ST_OK, 0, '0, 1'b1);
                end
            end
            CMD_SEARCH:
            begin
                for (i = 0; i < row_count && !hit; i++)
                begin
                    if (rows[i] == val)
                    begin
                        push_answer(ST_OK, i, '0, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    push_answer(ST_NOTFOUND, 0, '0, 1'b1);
            end
            default:
            begin
                if (row_count == 0)
                    push_answer(ST_EMPTY, 0, '0, 1'b1);
                else
                    for (i = 0; i < row_count; i++)
                        push_answer(ST_OK, i, rows[i], i + 1 == row_count);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            answer_q.delete();
            row_count = 0;
            fails     = 0;
            seen      = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status  = rsp.status;
                got.index   = rsp.index;
                got.element = rsp.element;
                got.last    = rsp.last;
                seen++;
                if (answer_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display({"result %0d with nothing owed: ",
                                  "status %0d index %0d element %0d last %0d"},
                                 seen, got.status, got.index, $signed(got.element),
                                 got.last);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"result %0d: expected status %0d index %0d ",
                                      "element %0d last %0d, got status %0d ",
                                      "index %0d element %0d last %0d"},
                                     seen, want.status, want.index,
                                     $signed(want.element), want.last,
                                     got.status, got.index, $signed(got.element),
                                     got.last);
                    end
                end
            end
            if (req.valid && req.ready)
                predict_answers(req.command, req.position, req.value);
            fail_count <= fails;
            pending    <= answer_q.size();
            checked    <= seen;
        end
    end

endmodule

// ----- sim/positional_array_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_table_tb
// Drives command items into the positional array table: a directed opening
// on the edge cases, then random fill, drain and mixed phases that take the
// table from empty to full and back. The sender works in bursts, the result
// side stalls on its own pattern, and a separate checker scores every result.
// ----------------------------------------------------------------------------
module positional_array_table_tb;
    import pat_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT        = 600000;

    localparam int PH_FILL  = 0;
    localparam int PH_MIXED = 1;
    localparam int PH_DRAIN = 2;

    localparam logic [VAL_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] V_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] V_NEG = 32'hffff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;
    int   checked;

    int   fill = 0;
    int   burst_left = 0;
    int   cmd_total [4] = '{0, 0, 0, 0};
    int   full_reached = 0;
    int   empty_reached = 0;
    int   full_refused = 0;

    int   rx_tick;
    int   rx_mode;
    int   rx_period;

    pat_req_if req_ch ();
    pat_rsp_if rsp_ch ();

    positional_array_table dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    positional_array_table_checker tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_tick      <= 0;
            rx_mode      <= 0;
            rx_period    <= 3;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (rx_tick % 48 == 0)
            begin
                rx_mode   <= $urandom_range(0, 3);
                rx_period <= $urandom_range(2, 5);
            end
            case (rx_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= (rx_tick % rx_period != 0);
                default: rsp_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return V_MIN;
                1:       return V_MAX;
                2:       return V_NEG;
                default: return '0;
            endcase
        end
        if (roll <= 5)
            return $urandom_range(0, 15) - 8;
        return $urandom();
    endfunction

    task automatic issue(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                         input logic [VAL_W-1:0] v);
        req_ch.valid    <= 1'b1;
        req_ch.command  <= c;
        req_ch.position <= p;
        req_ch.value    <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        cmd_total[c]++;
        if (c == CMD_INSERT && p <= fill && fill < DEPTH)
        begin
            fill++;
            if (fill == DEPTH)
                full_reached++;
        end
        else if (c == CMD_INSERT && p <= fill)
            full_refused++;
        else if (c == CMD_DELETE && p < fill)
        begin
            fill--;
            if (fill == 0)
                empty_reached++;
        end
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    task automatic random_item(input int kind);
        int roll;
        int ins_w;
        int del_w;
        int srch_w;
        int trav_w;
        logic [POS_W-1:0] p;
        roll = $urandom_range(0, 99);
        case (kind)
            PH_FILL:
            begin
                ins_w = 80; del_w = 5;  srch_w = 7;  trav_w = 4;
            end
            PH_DRAIN:
            begin
                ins_w = 5;  del_w = 78; srch_w = 7;  trav_w = 5;
            end
            default:
            begin
                ins_w = 30; del_w = 25; srch_w = 25; trav_w = 12;
            end
        endcase
        if (roll < ins_w)
        begin
            case ($urandom_range(0, 19))
                0:       p = POS_W'($urandom_range(fill + 1, 127));
                1:       p = POS_W'(fill);
                default: p = POS_W'($urandom_range(0, fill));
            endcase
            issue(CMD_INSERT, p, pick_value());
        end
        else if (roll < ins_w + del_w)
        begin
            if ($urandom_range(0, 19) == 0 || fill == 0)
                p = POS_W'($urandom_range(fill, 127));
            else
                p = POS_W'($urandom_range(0, fill - 1));
            issue(CMD_DELETE, p, $urandom());
        end
        else if (roll < ins_w + del_w + srch_w)
            issue(CMD_SEARCH, POS_W'($urandom_range(0, 127)), pick_value());
        else if (roll < ins_w + del_w + srch_w + trav_w)
            issue(CMD_TRAVERSE, POS_W'($urandom_range(0, 127)), $urandom());
        else
            issue(CMD_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)), $urandom());
    endtask

    initial
    begin
        int made;
        int phase;
        int kind;
        int span;
        int tail;

        req_ch.valid    <= 1'b0;
        req_ch.command  <= CMD_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        rst_n           <= 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every command is refused or finds nothing
        issue(CMD_TRAVERSE, 0, 0);
        issue(CMD_DELETE, 0, 0);
        issue(CMD_SEARCH, 0, 0);
        issue(CMD_INSERT, 1, 5);
        issue(CMD_INSERT, 127, 5);

        // build MIN, 0, MAX, -1, -1 through front, append and middle inserts
        issue(CMD_INSERT, 0, V_MAX);
        issue(CMD_INSERT, 0, V_MIN);
        issue(CMD_INSERT, 2, V_NEG);
        issue(CMD_INSERT, 1, '0);
        issue(CMD_INSERT, 4, V_NEG);
        issue(CMD_SEARCH, 0, V_NEG);
        issue(CMD_SEARCH, 0, V_MIN);
        issue(CMD_SEARCH, 0, 5);
        issue(CMD_TRAVERSE, 0, 0);

        // positions past the end
        issue(CMD_INSERT, 6, 1);
        issue(CMD_DELETE, 5, 0);
        issue(CMD_DELETE, 127, 0);

        // delete in the middle, at the front and at the end
        issue(CMD_DELETE, 2, 0);
        issue(CMD_DELETE, 0, 0);
        issue(CMD_DELETE, 2, 0);
        issue(CMD_SEARCH, 0, V_NEG);
        issue(CMD_TRAVERSE, 0, 0);

        made  = 0;
        phase = 0;
        while (made < RANDOM_ITEMS)
        begin
            if (phase % 2 == 1)
                kind = PH_MIXED;
            else if (phase % 4 == 0)
                kind = PH_FILL;
            else
                kind = PH_DRAIN;
            span = 0;
            tail = 0;
            while (made < RANDOM_ITEMS && tail < 8)
            begin
                random_item(kind);
                made++;
                span++;
                if ((kind == PH_FILL && fill == DEPTH) || (kind == PH_DRAIN && fill == 0)
                    || (kind == PH_MIXED && span >= 60))
                    tail++;
            end
            phase++;
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display({"covered %0d command items (%0d insert, %0d delete, %0d search, ",
                  "%0d traverse), %0d results compared"},
                 cmd_total[0] + cmd_total[1] + cmd_total[2] + cmd_total[3],
                 cmd_total[CMD_INSERT], cmd_total[CMD_DELETE], cmd_total[CMD_SEARCH],
                 cmd_total[CMD_TRAVERSE], checked);
        $display("table filled to %0d entries %0d times, emptied %0d times, %0d %s",
                 DEPTH, full_reached, empty_reached, full_refused,
                 "inserts refused as full");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        while (cycle_count < LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles with %0d results owed", cycle_count, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- positional_array_table.f -----
rtl/pat_pkg.sv
rtl/pat_if.sv
rtl/pat_front.sv
rtl/pat_queue.sv
rtl/pat_back.sv
rtl/positional_array_table.sv
sim/positional_array_table_checker.sv
sim/positional_array_table_tb.sv
